### design/assert_macros.svh
// Assertion macros shared by the checker files.
// No dependencies; included by bare file name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property at every rising edge, idle while reset is high.
`define SSP_ASSERT(lbl, clk, rst, prop) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("ssp assertion failed");

// Check a property at every rising edge, including during reset.
`define SSP_ASSERT_ALWAYS(lbl, clk, prop) \
  lbl: assert property (@(posedge clk) prop) \
    else $error("ssp assertion failed");

`endif

### design/ssp_pkg.sv
// Shared types and constants of the supply sag power limiter.
// No dependencies; imported by the top level and by ssp_band.
package ssp_pkg;

  localparam int LIM_W     = 16;
  localparam int DUTY_W    = 10;
  localparam int THR_W     = 12;
  localparam int PROD_W    = 2 * DUTY_W;

  localparam logic [6:0] SWING_LIMIT   = 7'd80;
  localparam logic [4:0] SWING_HOLD    = 5'd30;
  localparam logic [4:0] DEAD_BAND     = 5'd30;
  localparam logic [2:0] MAX_SAG_STEPS = 3'd4;

  // Register indexes of the configuration port
  localparam logic [2:0] REG_HALF_DUTY      = 3'd0;
  localparam logic [2:0] REG_LOW_DUTY       = 3'd1;
  localparam logic [2:0] REG_KNOB_LIMIT     = 3'd2;
  localparam logic [2:0] REG_TEMP_LIMIT     = 3'd3;
  localparam logic [2:0] REG_FAN_LIMIT      = 3'd4;
  localparam logic [2:0] REG_HIGH_THRESHOLD = 3'd5;
  localparam logic [2:0] REG_LOW_THRESHOLD  = 3'd6;

  typedef struct packed {
    logic [DUTY_W-1:0] half_duty;
    logic [DUTY_W-1:0] low_duty;
    logic [DUTY_W-1:0] knob_limit;
    logic [DUTY_W-1:0] temp_limit;
    logic [DUTY_W-1:0] fan_limit;
    logic [THR_W-1:0]  high_threshold;
    logic [THR_W-1:0]  low_threshold;
  } cfg_t;

  typedef struct packed {
    logic [4:0]       swing_count;
    logic [2:0]       sag_steps;
    logic             deep_sag;
    logic             recovering;
    logic [LIM_W-1:0] limit_value;
    logic             add_pending;
    logic             sub_pending;
  } band_state_t;

  typedef enum logic [8:0] {
    ST_IDLE   = 9'b000000001,
    ST_FILL   = 9'b000000010,
    ST_RMW_RD = 9'b000000100,
    ST_RMW_WR = 9'b000001000,
    ST_SUM    = 9'b000010000,
    ST_DIVA   = 9'b000100000,
    ST_MINMAX = 9'b001000000,
    ST_DIVB   = 9'b010000000,
    ST_BAND   = 9'b100000000
  } seq_state_t;

endpackage

### design/supply_sag_power_limiter.sv
// Top level of the supply sag power limiter: sequencer, rings, config port.
// Depends on ssp_pkg, ssp_ram, ssp_div and ssp_band.
//
//  channel | role          | fields (low bit up)
//  s_*     | input words   | sample, add_tick, sub_tick, requested_duty
//  m_*     | result words  | engine_limit, final_duty, filtered_level, unstable
//  APB     | configuration | registers 0..6 at byte address 4*i
//
// After accept, a word passes through the fast ring read-modify-write, its sweep, the
// window sweep, the average, scaling and band update steps, and the idle state before the
// next accept; the result is loaded into the output register on the band update step.
// The first word after reset fills both rings instead of the read-modify-write. Reset
// is synchronous; the rings need no clearing pass. A new word is taken while a result
// still waits in the output register; a stalled result holds the last step of the next word.
module supply_sag_power_limiter #(
  parameter int FAST_DEPTH  = 32,
  parameter int SLOW_DEPTH  = 25,
  parameter int SAMPLE_BITS = 12,
  parameter int FULL_DUTY   = 1000,
  localparam int IN_BITS  = SAMPLE_BITS + 2 + ssp_pkg::DUTY_W,
  localparam int IN_W     = ((IN_BITS + 7) / 8) * 8,
  localparam int OUT_BITS = 2 * ssp_pkg::DUTY_W + SAMPLE_BITS + 1,
  localparam int OUT_W    = ((OUT_BITS + 7) / 8) * 8
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             s_tvalid,
  output logic             s_tready,
  // sample, add_tick, sub_tick, requested_duty
  input  logic [IN_W-1:0]  s_tdata,
  output logic             m_tvalid,
  input  logic             m_tready,
  // engine_limit, final_duty, filtered_level, unstable
  output logic [OUT_W-1:0] m_tdata,
  input  logic             psel,
  input  logic             penable,
  input  logic             pwrite,
  input  logic [4:0]       paddr,
  input  logic [31:0]      pwdata,
  output logic [31:0]      prdata,
  output logic             pready
);
  import ssp_pkg::*;

  localparam int FAW    = (FAST_DEPTH > 1) ? $clog2(FAST_DEPTH) : 1;
  localparam int SAW    = (SLOW_DEPTH > 1) ? $clog2(SLOW_DEPTH) : 1;
  localparam int FILL_N = (FAST_DEPTH > SLOW_DEPTH) ? FAST_DEPTH : SLOW_DEPTH;
  localparam int CNTW   = $clog2(FILL_N + 1);
  localparam int SUM_W  = SAMPLE_BITS + $clog2(FAST_DEPTH);
  localparam int DCW    = (PROD_W > LIM_W) ? PROD_W : LIM_W;
  localparam int SB     = SAMPLE_BITS;

  seq_state_t state;
  logic [CNTW-1:0]   cnt;
  logic [SB-1:0]     smp;
  logic [DUTY_W-1:0] req;
  logic              primed;
  logic [FAW-1:0]    fast_pos;
  logic [SAW-1:0]    slow_pos;
  band_state_t       bstate;
  band_state_t       bnext;
  cfg_t              cfg;
  logic [SUM_W-1:0]  sum;
  logic [SB-1:0]     avg;
  logic [SB-1:0]     mx;
  logic [SB-1:0]     mn;
  logic [SB-1:0]     mx_next;
  logic [SB-1:0]     mn_next;
  logic              unstable_r;
  logic              out_valid;
  logic [OUT_W-1:0]  out_data;

  logic              fast_we;
  logic [FAW-1:0]    fast_waddr;
  logic [SB-1:0]     fast_wdata;
  logic [FAW-1:0]    fast_raddr;
  logic [SB-1:0]     fast_rdata;
  logic              slow_we;
  logic [SAW-1:0]    slow_waddr;
  logic [SB-1:0]     slow_wdata;
  logic [SAW-1:0]    slow_raddr;
  logic [SB-1:0]     slow_rdata;

  logic [SUM_W-1:0]  avg_q;
  logic [SB-1:0]     avg_c;
  logic [PROD_W-1:0] prod;
  logic [PROD_W-1:0] prod_r;
  logic [PROD_W-1:0] scaled_q;
  logic [PROD_W-1:0] scaled;
  logic [SUM_W-1:0]  sum_final;
  logic [DCW-1:0]    duty;
  logic              cfg_we;

  // Rings
  ssp_ram #(.WIDTH(SB), .DEPTH(FAST_DEPTH)) u_fast_ring (
    .clk(clk), .we(fast_we), .waddr(fast_waddr), .wdata(fast_wdata),
    .raddr(fast_raddr), .rdata(fast_rdata)
  );

  ssp_ram #(.WIDTH(SB), .DEPTH(SLOW_DEPTH)) u_slow_ring (
    .clk(clk), .we(slow_we), .waddr(slow_waddr), .wdata(slow_wdata),
    .raddr(slow_raddr), .rdata(slow_rdata)
  );

  // Constant dividers: ring average and knob scaling
  ssp_div #(.DW(SUM_W), .DIVISOR(FAST_DEPTH)) u_avg_div (
    .dividend(sum), .quotient(avg_q)
  );

  ssp_div #(.DW(PROD_W), .DIVISOR(FULL_DUTY)) u_duty_div (
    .dividend(prod_r), .quotient(scaled_q)
  );

  ssp_band #(
    .SLOW_DEPTH(SLOW_DEPTH), .SAMPLE_BITS(SB), .FULL_DUTY(FULL_DUTY)
  ) u_band (
    .cur(bstate), .cfg(cfg), .avg(avg), .unstable(unstable_r), .nxt(bnext)
  );

  // Fast ring ports: fill, read-modify-write, sweep
  always_comb begin
    fast_we    = 1'b0;
    fast_waddr = fast_pos;
    fast_wdata = smp;
    fast_raddr = fast_pos;
    if (state == ST_FILL) begin
      fast_we    = cnt < CNTW'(FAST_DEPTH);
      fast_waddr = cnt[FAW-1:0];
    end else if (state == ST_RMW_WR) begin
      fast_we    = 1'b1;
      fast_wdata = SB'(({1'b0, fast_rdata} + {1'b0, smp}) >> 1);
    end else if (state == ST_SUM) begin
      fast_raddr = (cnt == CNTW'(FAST_DEPTH)) ? '0 : cnt[FAW-1:0];
    end
  end

  // Window ring ports: fill, average write, sweep
  always_comb begin
    slow_we    = 1'b0;
    slow_waddr = slow_pos;
    slow_wdata = avg_c;
    slow_raddr = (cnt == CNTW'(SLOW_DEPTH)) ? '0 : cnt[SAW-1:0];
    if (state == ST_FILL) begin
      slow_we    = cnt < CNTW'(SLOW_DEPTH);
      slow_waddr = cnt[SAW-1:0];
      slow_wdata = smp;
    end else if (state == ST_DIVA) begin
      slow_we = 1'b1;
    end
  end

  // Sum accumulation, average and knob product
  assign sum_final = sum + SUM_W'(fast_rdata);
  assign avg_c     = SB'(avg_q);
  assign prod      = PROD_W'(req) * PROD_W'(cfg.knob_limit);

  // Window extremes
  always_comb begin
    if (cnt == CNTW'(1)) begin
      mx_next = slow_rdata;
      mn_next = slow_rdata;
    end else begin
      mx_next = (slow_rdata > mx) ? slow_rdata : mx;
      mn_next = (slow_rdata < mn) ? slow_rdata : mn;
    end
  end

  // Clamp the scaled request by temperature, engine limit and fan
  always_comb begin
    duty = DCW'(scaled);
    if (duty >= DCW'(cfg.temp_limit)) duty = DCW'(cfg.temp_limit);
    if (duty >= DCW'(bnext.limit_value)) duty = DCW'(bnext.limit_value);
    if (duty >= DCW'(cfg.fan_limit)) duty = DCW'(cfg.fan_limit);
  end

  // Sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_IDLE;
      cnt        <= '0;
      primed     <= 1'b0;
      fast_pos   <= '0;
      slow_pos   <= '0;
      bstate.swing_count <= '0;
      bstate.sag_steps   <= '0;
      bstate.deep_sag    <= 1'b0;
      bstate.recovering  <= 1'b0;
      bstate.limit_value <= LIM_W'(FULL_DUTY);
      bstate.add_pending <= 1'b0;
      bstate.sub_pending <= 1'b0;
    end else begin
      unique case (state)
        ST_IDLE: begin
          if (s_tvalid) begin
            smp <= s_tdata[SB-1:0];
            req <= s_tdata[SB+2+DUTY_W-1:SB+2];
            bstate.add_pending <= bstate.add_pending | s_tdata[SB];
            bstate.sub_pending <= bstate.sub_pending | s_tdata[SB+1];
            cnt   <= '0;
            state <= primed ? ST_RMW_RD : ST_FILL;
          end
        end
        ST_FILL: begin
          if (cnt == CNTW'(FILL_N - 1)) begin
            primed <= 1'b1;
            cnt    <= '0;
            sum    <= '0;
            state  <= ST_SUM;
          end else begin
            cnt <= cnt + 1'b1;
          end
        end
        ST_RMW_RD: begin
          state <= ST_RMW_WR;
        end
        ST_RMW_WR: begin
          fast_pos <= (fast_pos == FAW'(FAST_DEPTH - 1)) ? '0 : fast_pos + 1'b1;
          cnt      <= '0;
          sum      <= '0;
          state    <= ST_SUM;
        end
        ST_SUM: begin
          if (cnt != '0) sum <= sum_final;
          if (cnt == CNTW'(FAST_DEPTH)) begin
            state <= ST_DIVA;
          end else begin
            cnt <= cnt + 1'b1;
          end
        end
        ST_DIVA: begin
          avg      <= avg_c;
          prod_r   <= prod;
          slow_pos <= (slow_pos == SAW'(SLOW_DEPTH - 1)) ? '0 : slow_pos + 1'b1;
          cnt      <= '0;
          state    <= ST_MINMAX;
        end
        ST_MINMAX: begin
          if (cnt != '0) begin
            mx <= mx_next;
            mn <= mn_next;
          end
          if (cnt == CNTW'(SLOW_DEPTH)) begin
            unstable_r <= (mx_next - mn_next) > SB'(SWING_LIMIT);
            state      <= ST_DIVB;
          end else begin
            cnt <= cnt + 1'b1;
          end
        end
        ST_DIVB: begin
          scaled <= scaled_q;
          state  <= ST_BAND;
        end
        ST_BAND: begin
          if (!out_valid || m_tready) begin
            bstate    <= bnext;
            out_data  <= OUT_W'({unstable_r, avg, duty[DUTY_W-1:0],
                                 bnext.limit_value[DUTY_W-1:0]});
            state     <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  // Output valid: load on the band step, drop when taken
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (state == ST_BAND && (!out_valid || m_tready)) begin
      out_valid <= 1'b1;
    end else if (m_tready) begin
      out_valid <= 1'b0;
    end
  end

  assign s_tready = (state == ST_IDLE);
  assign m_tvalid = out_valid;
  assign m_tdata  = out_data;

  // Configuration registers
  assign pready = 1'b1;
  assign cfg_we = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.half_duty      <= 10'd500;
      cfg.low_duty       <= 10'd300;
      cfg.knob_limit     <= 10'd1000;
      cfg.temp_limit     <= 10'd1000;
      cfg.fan_limit      <= 10'd1000;
      cfg.high_threshold <= 12'd1645;
      cfg.low_threshold  <= 12'd1475;
    end else if (cfg_we) begin
      unique case (paddr[4:2])
        REG_HALF_DUTY:      cfg.half_duty      <= pwdata[DUTY_W-1:0];
        REG_LOW_DUTY:       cfg.low_duty       <= pwdata[DUTY_W-1:0];
        REG_KNOB_LIMIT:     cfg.knob_limit     <= pwdata[DUTY_W-1:0];
        REG_TEMP_LIMIT:     cfg.temp_limit     <= pwdata[DUTY_W-1:0];
        REG_FAN_LIMIT:      cfg.fan_limit      <= pwdata[DUTY_W-1:0];
        REG_HIGH_THRESHOLD: cfg.high_threshold <= pwdata[THR_W-1:0];
        REG_LOW_THRESHOLD:  cfg.low_threshold  <= pwdata[THR_W-1:0];
        default: ;
      endcase
    end
  end

  // Register read back
  always_comb begin
    unique case (paddr[4:2])
      REG_HALF_DUTY:      prdata = 32'(cfg.half_duty);
      REG_LOW_DUTY:       prdata = 32'(cfg.low_duty);
      REG_KNOB_LIMIT:     prdata = 32'(cfg.knob_limit);
      REG_TEMP_LIMIT:     prdata = 32'(cfg.temp_limit);
      REG_FAN_LIMIT:      prdata = 32'(cfg.fan_limit);
      REG_HIGH_THRESHOLD: prdata = 32'(cfg.high_threshold);
      REG_LOW_THRESHOLD:  prdata = 32'(cfg.low_threshold);
      default:            prdata = '0;
    endcase
  end

endmodule

### design/ssp_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module ssp_ram #(
  parameter int WIDTH = 12,
  parameter int DEPTH = 32,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port and registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

### design/ssp_div.sv
// Division by a constant through reciprocal multiplication, exact over the dividend range.
// Depends on nothing; shared by the ring average and the duty scaling.
module ssp_div #(
  parameter int DW      = 20,
  parameter int DIVISOR = 1000
) (
  input  logic [DW-1:0] dividend,
  output logic [DW-1:0] quotient
);

  localparam int L  = (DIVISOR > 1) ? $clog2(DIVISOR) : 0;
  localparam int S  = DW + L;
  localparam int MW = DW + 1;
  localparam int PW = DW + MW;
  localparam logic [MW-1:0] RECIP =
    MW'(((64'd1 << S) + 64'(DIVISOR) - 64'd1) / 64'(DIVISOR));

  logic [PW-1:0] prod;

  // Multiply by the rounded-up reciprocal and drop the fraction bits
  assign prod     = PW'(dividend) * PW'(RECIP);
  assign quotient = DW'(prod >> S);

endmodule

### design/ssp_band.sv
// Band decision: swing counter, sag steps and engine limit update.
// Depends on ssp_pkg for the state and configuration structs.
module ssp_band #(
  parameter int SLOW_DEPTH  = 25,
  parameter int SAMPLE_BITS = 12,
  parameter int FULL_DUTY   = 1000
) (
  input  ssp_pkg::band_state_t   cur,
  input  ssp_pkg::cfg_t          cfg,
  input  logic [SAMPLE_BITS-1:0] avg,
  input  logic                   unstable,
  output ssp_pkg::band_state_t   nxt
);
  import ssp_pkg::*;

  localparam int CW = ((SAMPLE_BITS > THR_W) ? SAMPLE_BITS : THR_W) + 1;
  localparam logic [10:0]      SLOW_K = 11'(SLOW_DEPTH);
  localparam logic [LIM_W-1:0] FULL_K = LIM_W'(FULL_DUTY);

  always_comb begin
    logic [4:0]       swing;
    logic [CW-1:0]    a;
    logic [CW-1:0]    h;
    logic [CW-1:0]    l;
    logic [LIM_W-1:0] half;
    logic [LIM_W-1:0] lowd;
    logic [LIM_W-1:0] lim;
    nxt  = cur;
    a    = CW'(avg);
    h    = CW'(cfg.high_threshold);
    l    = CW'(cfg.low_threshold);
    half = LIM_W'(cfg.half_duty);
    lowd = LIM_W'(cfg.low_duty);
    lim  = cur.limit_value;

    // Reload the swing counter with SWING_HOLD on instability, else let it decay
    if (unstable) begin
      swing = SWING_HOLD;
    end else if (11'(cur.swing_count) > SLOW_K) begin
      swing = 5'(11'(cur.swing_count) - SLOW_K);
    end else begin
      swing = '0;
    end
    nxt.swing_count = swing;

    // Nominal band first, then moderate sag, then deep sag
    priority if (a >= h + CW'(DEAD_BAND)) begin
      nxt.sag_steps  = '0;
      nxt.deep_sag   = 1'b0;
      nxt.recovering = 1'b1;
      if (swing == SWING_HOLD) begin
        nxt.swing_count = swing - 1'b1;
        if (lim > half) lim = lim - 1'b1;
        if (lim < half) lim = half;
      end else if (swing == 5'd0 && cur.add_pending) begin
        nxt.add_pending = 1'b0;
        if (lim < FULL_K) lim = lim + 1'b1;
      end
    end else if (a > l && (a <= h || cur.sag_steps == MAX_SAG_STEPS)) begin
      if (cur.sub_pending) begin
        nxt.sub_pending = 1'b0;
        if (cur.sag_steps < MAX_SAG_STEPS) nxt.sag_steps = cur.sag_steps + 1'b1;
        nxt.deep_sag   = 1'b0;
        nxt.recovering = 1'b0;
        if (lim > half) lim = (lim >= LIM_W'(2)) ? lim - LIM_W'(2) : '0;
        else if (lim < half) lim = lim + 1'b1;
      end
    end else if (a <= l || cur.deep_sag) begin
      if (cur.sub_pending) begin
        nxt.sub_pending = 1'b0;
        nxt.deep_sag    = 1'b1;
        nxt.sag_steps   = '0;
        nxt.recovering  = 1'b0;
        if (lim > lowd) lim = (lim >= LIM_W'(2)) ? lim - LIM_W'(2) : '0;
        else lim = lowd;
      end
    end else begin
      lim = cur.limit_value;
    end
    nxt.limit_value = lim;
  end

endmodule

### design/ssp_checker.sv
// Port-level checks of the supply sag power limiter, bound to the top level.
// Depends on assert_macros.svh.
`include "assert_macros.svh"

module ssp_checker #(
  parameter int OUT_W = 40
) (
  input logic             clk,
  input logic             rst,
  input logic             s_tvalid,
  input logic             s_tready,
  input logic             m_tvalid,
  input logic             m_tready,
  input logic [OUT_W-1:0] m_tdata
);

  // No result is offered right after reset
  `SSP_ASSERT_ALWAYS(a_reset_empty, clk, rst |=> !m_tvalid)

  // A stalled result word holds
  `SSP_ASSERT(a_stall_hold, clk, rst, m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))

  // One word at a time: input closes after an accept
  `SSP_ASSERT(a_one_in_flight, clk, rst, s_tvalid && s_tready |=> !s_tready)

endmodule

bind supply_sag_power_limiter ssp_checker #(.OUT_W(OUT_W)) u_ssp_checker (
  .clk(clk), .rst(rst), .s_tvalid(s_tvalid), .s_tready(s_tready),
  .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
);
